>>> hw/rtl/ftc_pkg.sv
// shared types and constants for the frustum culling test
package ftc_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int PLANE_COUNT     = 6;
  localparam int PART_W          = 16;
  localparam int PLANE_W         = 4 * PART_W;
  localparam int PLANE_IDX_W     = 3;
  localparam int CFG_IDX_W       = 3;
  localparam int QUEUE_DEPTH     = 2;

  // request kind codes as seen on the input
  localparam logic [1:0] KIND_POINT  = 2'd0;
  localparam logic [1:0] KIND_SPHERE = 2'd1;
  localparam logic [1:0] KIND_BOX    = 2'd2;

  typedef enum logic [1:0] {
    CLS_POINT,
    CLS_SPHERE,
    CLS_BOX,
    CLS_NONE
  } class_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_L2,
    ST_SQRT,
    ST_DLOAD,
    ST_DIV,
    ST_EVAL,
    ST_DONE
  } state_t;

endpackage

>>> hw/rtl/frustum_culling_test_core.sv
// A point, box or sphere request is popped in IDLE, tested plane by plane in EVAL and
// posted from DONE once the result slot is free; the unused kind goes straight to DONE.
// A new request is taken only after the last result is posted (issue, evaluation, post).
// The first sphere after reset or a plane write adds normalization of all six planes
// (sqrt and divide one bit a cycle).
// Reset: synchronous active-low rst_n clears the request queue, the result slot, plane registers and the flag.
module frustum_culling_test_core import ftc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [1:0]             in_kind,
  input  logic [COORD_WIDTH-1:0] in_first_x,
  input  logic [COORD_WIDTH-1:0] in_first_y,
  input  logic [COORD_WIDTH-1:0] in_first_z,
  input  logic [COORD_WIDTH-1:0] in_second_x,
  input  logic [COORD_WIDTH-1:0] in_second_y,
  input  logic [COORD_WIDTH-1:0] in_second_z,
  input  logic [COORD_WIDTH-2:0] in_radius,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic                   out_visible,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [PLANE_W-1:0]     cfg_wdata
);

  logic [PLANE_W-1:0]       plane_r [PLANE_COUNT];
  logic                     cfg_hit;
  logic                     q_empty, q_pop;
  class_t                   q_cls;
  logic [7*COORD_WIDTH-2:0] q_data;

  assign cfg_hit = cfg_we && (cfg_index < CFG_IDX_W'(PLANE_COUNT));

  // plane registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        plane_r[i] <= '0;
      end
    end else if (cfg_hit) begin
      plane_r[cfg_index] <= cfg_wdata;
    end
  end

  // request decode and queue
  ftc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_kind (in_kind),
    .in_data ({in_first_x, in_first_y, in_first_z,
               in_second_x, in_second_y, in_second_z, in_radius}),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_cls   (q_cls),
    .q_data  (q_data)
  );

  // test engine
  ftc_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .planes      (plane_r),
    .norm_clr    (cfg_hit),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_cls       (q_cls),
    .q_data      (q_data),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_visible (out_visible)
  );

endmodule

>>> hw/rtl/ftc_front.sv
// front end: request decode and a short queue toward the engine
module ftc_front import ftc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic [1:0]               in_kind,
  input  logic [7*COORD_WIDTH-2:0] in_data,
  output logic                     q_empty,
  input  logic                     q_pop,
  output class_t                   q_cls,
  output logic [7*COORD_WIDTH-2:0] q_data
);

  localparam int DATA_W = 7 * COORD_WIDTH - 1;

  class_t              cls_mem [QUEUE_DEPTH];
  logic [DATA_W-1:0]   data_mem [QUEUE_DEPTH];
  logic                wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  class_t              cls_dec;
  logic                push_ok;

  // classify the request kind
  always_comb begin
    unique case (in_kind)
      KIND_POINT:  cls_dec = CLS_POINT;
      KIND_SPHERE: cls_dec = CLS_SPHERE;
      KIND_BOX:    cls_dec = CLS_BOX;
      default:     cls_dec = CLS_NONE;
    endcase
  end

  assign in_full = (cnt_r == 2'(QUEUE_DEPTH));
  assign q_empty = (cnt_r == 2'd0);
  assign push_ok = in_push && !in_full;
  assign q_cls   = cls_mem[rp_r];
  assign q_data  = data_mem[rp_r];

  // pointer and count update
  always_comb begin
    wp_nxt  = wp_r ^ push_ok;
    rp_nxt  = rp_r ^ q_pop;
    cnt_nxt = cnt_r + 2'(push_ok) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      cls_mem[wp_r]  <= cls_dec;
      data_mem[wp_r] <= in_data;
    end
  end

endmodule

>>> hw/rtl/ftc_back.sv
// back end: plane normalization and per-plane distance tests
module ftc_back import ftc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [PLANE_W-1:0]       planes [PLANE_COUNT],
  input  logic                     norm_clr,
  input  logic                     q_empty,
  output logic                     q_pop,
  input  class_t                   q_cls,
  input  logic [7*COORD_WIDTH-2:0] q_data,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic                     out_visible
);

  localparam int CW   = COORD_WIDTH;
  localparam int XW   = 32 + 2 * FRAC_BITS;
  localparam int SW   = 16 + FRAC_BITS;
  localparam int NW   = 18 + 2 * FRAC_BITS;
  localparam int HALF = XW / 2;
  localparam int IT_W = $clog2(NW + 1);
  localparam int PW   = PART_W + CW;
  localparam int DW   = ((CW > FRAC_BITS) ? CW : FRAC_BITS) + PART_W + 3;

  state_t                   st_r, st_nxt;
  class_t                   cls_r, cls_nxt;
  logic signed [CW-1:0]     x0_r, y0_r, z0_r, x1_r, y1_r, z1_r;
  logic [CW-2:0]            rad_r;
  logic [PLANE_IDX_W-1:0]   pi_r, pi_nxt;
  logic [1:0]               k_r, k_nxt;
  logic [IT_W-1:0]          it_r, it_nxt;
  logic                     nrm_ok_r, nrm_ok_nxt;
  logic [PLANE_W-1:0]       nrm_mem [PLANE_COUNT];
  logic [PLANE_W-1:0]       nrm_acc_r, nrm_acc_nxt;
  logic                     nrm_we;
  logic [PLANE_W-1:0]       nrm_wdata;
  logic [31:0]              l2_r, l2_nxt;
  logic [XW-1:0]            x_r, x_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [SW-1:0]            len_r, len_nxt;
  logic [SW:0]              rem_r, rem_nxt;
  logic [NW-1:0]            q_r, q_nxt;
  logic signed [PW-1:0]     pa0_r, pa1_r, pb0_r, pb1_r, pc0_r, pc1_r;
  logic signed [PART_W-1:0] pd_r;
  logic                     pv_r, pv_nxt;
  logic                     vis_r, vis_nxt;
  logic                     out_vld_r, out_vld_nxt, out_vis_r, out_vis_nxt;

  logic [PLANE_IDX_W-1:0]   sel_idx;
  logic [PLANE_W-1:0]       raw_pl, eval_pl;
  logic signed [PART_W-1:0] cur_part;
  logic [31:0]              sq, l2_sum;
  logic [XW-1:0]            sq_t;
  logic                     sq_ge;
  logic [SW+1:0]            rem2;
  logic                     qbit;
  logic [NW-1:0]            q_fin;
  logic [PART_W-1:0]        sat_part;
  logic [PART_W:0]          mag;
  logic signed [DW-1:0]     sx, sy, sz, dsum, thr;
  logic                     fail;
  logic                     start, last_plane;

  assign sel_idx   = (pi_r < PLANE_IDX_W'(PLANE_COUNT)) ? pi_r : '0;
  assign raw_pl    = planes[sel_idx];
  assign eval_pl   = (cls_r == CLS_SPHERE) ? nrm_mem[sel_idx] : raw_pl;
  assign cur_part  = raw_pl[PART_W*k_r +: PART_W];
  assign start     = (st_r == ST_IDLE) && !q_empty;
  assign q_pop     = start;
  assign last_plane = (pi_r == PLANE_IDX_W'(PLANE_COUNT - 1));
  assign out_empty  = !out_vld_r;
  assign out_visible = out_vis_r;

  // squared length term and sqrt step
  always_comb begin
    sq     = 32'(cur_part * cur_part);
    l2_sum = l2_r + sq;
    sq_t   = res_r + bit_r;
    sq_ge  = (x_r >= sq_t);
  end

  // restoring divide step and saturation
  always_comb begin
    rem2  = {rem_r, q_r[NW-1]};
    qbit  = (rem2 >= (SW+2)'(len_r));
    q_fin = {q_r[NW-2:0], qbit};
    if (cur_part[PART_W-1]) begin
      sat_part = (q_fin > NW'(32768)) ? 16'h8000 : PART_W'(-q_fin);
    end else begin
      sat_part = (q_fin > NW'(32767)) ? 16'h7fff : q_fin[PART_W-1:0];
    end
    mag = cur_part[PART_W-1] ? (PART_W+1)'(-$signed({cur_part[PART_W-1], cur_part}))
                             : {1'b0, cur_part};
  end

  // plane sum and per-kind test
  always_comb begin
    sx   = (cls_r == CLS_BOX && pa1_r > pa0_r) ? DW'(pa1_r) : DW'(pa0_r);
    sy   = (cls_r == CLS_BOX && pb1_r > pb0_r) ? DW'(pb1_r) : DW'(pb0_r);
    sz   = (cls_r == CLS_BOX && pc1_r > pc0_r) ? DW'(pc1_r) : DW'(pc0_r);
    dsum = sx + sy + sz + (DW'(pd_r) <<< FRAC_BITS);
    thr  = $signed(DW'(rad_r)) <<< FRAC_BITS;
    case (cls_r)
      CLS_SPHERE: fail = (dsum < -thr);
      CLS_BOX:    fail = (dsum <= 0);
      default:    fail = (dsum < 0);
    endcase
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (start) begin
          if (q_cls == CLS_NONE) begin
            st_nxt = ST_DONE;
          end else if (q_cls == CLS_SPHERE && !nrm_ok_r) begin
            st_nxt = ST_L2;
          end else begin
            st_nxt = ST_EVAL;
          end
        end
      end
      ST_L2: begin
        if (k_r == 2'd2) begin
          if (l2_sum != 32'd0) begin
            st_nxt = ST_SQRT;
          end else if (last_plane) begin
            st_nxt = ST_EVAL;
          end
        end
      end
      ST_SQRT: begin
        if (it_r == IT_W'(HALF - 1)) begin
          st_nxt = ST_DLOAD;
        end
      end
      ST_DLOAD: st_nxt = ST_DIV;
      ST_DIV: begin
        if (it_r == IT_W'(NW - 1)) begin
          if (k_r != 2'd3) begin
            st_nxt = ST_DLOAD;
          end else if (last_plane) begin
            st_nxt = ST_EVAL;
          end else begin
            st_nxt = ST_L2;
          end
        end
      end
      ST_EVAL: begin
        if (pi_r == PLANE_IDX_W'(PLANE_COUNT) && !pv_r) begin
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_r || out_pop) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // datapath and counters
  always_comb begin
    cls_nxt     = cls_r;
    pi_nxt      = pi_r;
    k_nxt       = k_r;
    it_nxt      = it_r;
    nrm_ok_nxt  = nrm_ok_r;
    nrm_acc_nxt = nrm_acc_r;
    nrm_we      = 1'b0;
    nrm_wdata   = nrm_acc_r;
    l2_nxt      = l2_r;
    x_nxt       = x_r;
    res_nxt     = res_r;
    bit_nxt     = bit_r;
    len_nxt     = len_r;
    rem_nxt     = rem_r;
    q_nxt       = q_r;
    pv_nxt      = 1'b0;
    vis_nxt     = vis_r;
    out_vld_nxt = out_vld_r && !out_pop;
    out_vis_nxt = out_vis_r;
    unique case (st_r)
      ST_IDLE: begin
        if (start) begin
          cls_nxt = q_cls;
          pi_nxt  = '0;
          k_nxt   = 2'd0;
          l2_nxt  = 32'd0;
          vis_nxt = 1'b1;
        end
      end
      ST_L2: begin
        l2_nxt = l2_sum;
        k_nxt  = k_r + 2'd1;
        if (k_r == 2'd2) begin
          k_nxt   = 2'd0;
          x_nxt   = XW'(l2_sum) << (2 * FRAC_BITS);
          res_nxt = '0;
          bit_nxt = XW'(1) << (XW - 2);
          it_nxt  = '0;
          if (l2_sum == 32'd0) begin
            nrm_we    = 1'b1;
            nrm_wdata = raw_pl;
            l2_nxt    = 32'd0;
            pi_nxt    = last_plane ? '0 : pi_r + 1'b1;
            if (last_plane) begin
              nrm_ok_nxt = 1'b1;
            end
          end
        end
      end
      ST_SQRT: begin
        if (sq_ge) begin
          x_nxt   = x_r - sq_t;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        it_nxt  = it_r + 1'b1;
        len_nxt = res_nxt[SW-1:0];
      end
      ST_DLOAD: begin
        rem_nxt = '0;
        q_nxt   = (NW'(mag) << (2 * FRAC_BITS)) + NW'(len_r >> 1);
        it_nxt  = '0;
      end
      ST_DIV: begin
        rem_nxt = qbit ? (SW+1)'(rem2 - (SW+2)'(len_r)) : rem2[SW:0];
        q_nxt   = q_fin;
        it_nxt  = it_r + 1'b1;
        if (it_r == IT_W'(NW - 1)) begin
          nrm_acc_nxt[PART_W*k_r +: PART_W] = sat_part;
          k_nxt = k_r + 2'd1;
          if (k_r == 2'd3) begin
            nrm_we    = 1'b1;
            nrm_wdata = nrm_acc_nxt;
            l2_nxt    = 32'd0;
            pi_nxt    = last_plane ? '0 : pi_r + 1'b1;
            if (last_plane) begin
              nrm_ok_nxt = 1'b1;
            end
          end
        end
      end
      ST_EVAL: begin
        if (pi_r < PLANE_IDX_W'(PLANE_COUNT)) begin
          pv_nxt = 1'b1;
          pi_nxt = pi_r + 1'b1;
        end
        if (pv_r && fail) begin
          vis_nxt = 1'b0;
        end
      end
      ST_DONE: begin
        // post once the result slot is free or being emptied
        if (!out_vld_r || out_pop) begin
          out_vld_nxt = 1'b1;
          out_vis_nxt = vis_r;
        end
      end
      default: ;
    endcase
    if (norm_clr) begin
      nrm_ok_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      nrm_ok_r  <= 1'b0;
      out_vld_r <= 1'b0;
      pv_r      <= 1'b0;
      pi_r      <= '0;
      k_r       <= 2'd0;
      it_r      <= '0;
    end else begin
      st_r      <= st_nxt;
      nrm_ok_r  <= nrm_ok_nxt;
      out_vld_r <= out_vld_nxt;
      pv_r      <= pv_nxt;
      pi_r      <= pi_nxt;
      k_r       <= k_nxt;
      it_r      <= it_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cls_r     <= cls_nxt;
    nrm_acc_r <= nrm_acc_nxt;
    l2_r      <= l2_nxt;
    x_r       <= x_nxt;
    res_r     <= res_nxt;
    bit_r     <= bit_nxt;
    len_r     <= len_nxt;
    rem_r     <= rem_nxt;
    q_r       <= q_nxt;
    vis_r     <= vis_nxt;
    out_vis_r <= out_vis_nxt;
    if (start) begin
      {x0_r, y0_r, z0_r, x1_r, y1_r, z1_r, rad_r} <= q_data;
    end
    // one multiply per axis bound, summed next cycle
    pa0_r <= PW'($signed(eval_pl[PART_W*0 +: PART_W]) * x0_r);
    pa1_r <= PW'($signed(eval_pl[PART_W*0 +: PART_W]) * x1_r);
    pb0_r <= PW'($signed(eval_pl[PART_W*1 +: PART_W]) * y0_r);
    pb1_r <= PW'($signed(eval_pl[PART_W*1 +: PART_W]) * y1_r);
    pc0_r <= PW'($signed(eval_pl[PART_W*2 +: PART_W]) * z0_r);
    pc1_r <= PW'($signed(eval_pl[PART_W*2 +: PART_W]) * z1_r);
    pd_r  <= $signed(eval_pl[PART_W*3 +: PART_W]);
  end

  // normalized plane store
  always_ff @(posedge clk) begin
    if (nrm_we) begin
      nrm_mem[sel_idx] <= nrm_wdata;
    end
  end

`ifndef SYNTHESIS
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_DONE |=> out_vld_r) else $error("result not posted");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> st_r == ST_IDLE && !q_empty) else $error("pop while busy");
  a_eval_cls: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_EVAL |-> cls_r != CLS_NONE) else $error("bad eval class");
`endif

endmodule

>>> test/frustum_culling_test_checker.sv
// request/result checker with its own culling predictor for the frustum culling test
`timescale 1ns / 1ps

module frustum_culling_test_checker import ftc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_first_x,
  input  logic [15:0] in_first_y,
  input  logic [15:0] in_first_z,
  input  logic [15:0] in_second_x,
  input  logic [15:0] in_second_y,
  input  logic [15:0] in_second_z,
  input  logic [14:0] in_radius,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic        out_visible,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          checked_count
);

  localparam int FRAC = FRAC_BITS_DEF;

  logic [PLANE_W-1:0] plane_set  [PLANE_COUNT];
  logic [PLANE_W-1:0] unit_plane [PLANE_COUNT];
  bit                 unit_valid;
  bit                 visible_q [$];

  // signed plane component k
  function automatic longint comp(logic [PLANE_W-1:0] p, int k);
    return longint'($signed(p[PART_W*k +: PART_W]));
  endfunction

  // floor square root, bit by bit
  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // rounded divide by the plane length, saturated to 16 bits
  function automatic logic [PART_W-1:0] scale_comp(longint v, longint unsigned len);
    longint unsigned mag, q;
    longint s;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    q = ((mag << (2 * FRAC)) + len / 2) / len;
    if (v < 0) s = (q > 32768) ? -32768 : -longint'(q);
    else       s = (q > 32767) ? 32767 : longint'(q);
    return s[PART_W-1:0];
  endfunction

  // unit-length copies of all six planes
  function automatic void normalize_planes();
    longint a, b, c;
    longint unsigned l2, len;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      a = comp(plane_set[i], 0);
      b = comp(plane_set[i], 1);
      c = comp(plane_set[i], 2);
      l2 = a * a + b * b + c * c;
      if (l2 == 0) begin
        unit_plane[i] = plane_set[i];
      end else begin
        len = root_floor(l2 << (2 * FRAC));
        for (int k = 0; k < 4; k++)
          unit_plane[i][PART_W*k +: PART_W] = scale_comp(comp(plane_set[i], k), len);
      end
    end
    unit_valid = 1;
  endfunction

  function automatic longint plane_dist(logic [PLANE_W-1:0] p, longint x, longint y,
                                        longint z);
    return comp(p, 0) * x + comp(p, 1) * y + comp(p, 2) * z + (comp(p, 3) <<< FRAC);
  endfunction

  function automatic longint larger(longint u, longint v);
    return (u > v) ? u : v;
  endfunction

  function automatic bit predict_visible();
    longint x0, y0, z0, x1, y1, z1, r, a, b, c, s;
    bit vis;
    x0 = longint'($signed(in_first_x));
    y0 = longint'($signed(in_first_y));
    z0 = longint'($signed(in_first_z));
    x1 = longint'($signed(in_second_x));
    y1 = longint'($signed(in_second_y));
    z1 = longint'($signed(in_second_z));
    r  = longint'(in_radius);
    vis = 1;
    case (in_kind)
      KIND_POINT: begin
        for (int i = 0; i < PLANE_COUNT; i++)
          if (plane_dist(plane_set[i], x0, y0, z0) < 0) vis = 0;
      end
      KIND_SPHERE: begin
        if (!unit_valid) normalize_planes();
        for (int i = 0; i < PLANE_COUNT; i++)
          if (plane_dist(unit_plane[i], x0, y0, z0) < -(r <<< FRAC)) vis = 0;
      end
      KIND_BOX: begin
        for (int i = 0; i < PLANE_COUNT; i++) begin
          a = comp(plane_set[i], 0);
          b = comp(plane_set[i], 1);
          c = comp(plane_set[i], 2);
          s = larger(a * x0, a * x1) + larger(b * y0, b * y1) + larger(c * z0, c * z1)
            + (comp(plane_set[i], 3) <<< FRAC);
          if (s <= 0) vis = 0;
        end
      end
      default: vis = 1;
    endcase
    return vis;
  endfunction

  assign pending = visible_q.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        plane_set[i]  = '0;
        unit_plane[i] = '0;
      end
      unit_valid    = 0;
      visible_q.delete();
      fail_count    <= 0;
      checked_count <= 0;
    end else begin
      // plane writes; indexes past the last plane are dropped
      if (cfg_we && cfg_index < PLANE_COUNT) begin
        plane_set[cfg_index] = cfg_wdata;
        unit_valid = 0;
      end
      // accepted request
      if (in_push && !in_full) visible_q.push_back(predict_visible());
      // accepted result
      if (out_pop && !out_empty) begin
        if (visible_q.size() == 0) begin
          $error("visible: result with no request waiting, actual %0d", out_visible);
          fail_count <= fail_count + 1;
        end else begin
          bit want;
          want = visible_q.pop_front();
          if (want !== out_visible) begin
            $error("visible: expected %0d, actual %0d", want, out_visible);
            fail_count <= fail_count + 1;
          end
          checked_count <= checked_count + 1;
        end
      end
    end
  end

endmodule

>>> test/frustum_culling_test_core_test.sv
// stimulus and verdict for the frustum culling test core
`timescale 1ns / 1ps

module frustum_culling_test_core_test;
  import ftc_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [2:0] REG_RIGHT  = 3'd0;
  localparam logic [2:0] REG_LEFT   = 3'd1;
  localparam logic [2:0] REG_BOTTOM = 3'd2;
  localparam logic [2:0] REG_TOP    = 3'd3;
  localparam logic [2:0] REG_BACK   = 3'd4;
  localparam logic [2:0] REG_FRONT  = 3'd5;
  localparam logic [2:0] REG_BEYOND = 3'd6;
  localparam int PHASES     = 8;
  localparam int PER_PHASE  = 80;
  localparam int DRAIN_WAIT = 30;

  logic        clk, rst_n;
  logic        in_push, in_full, out_empty, out_pop, out_visible, cfg_we;
  logic [1:0]  in_kind;
  logic [15:0] in_first_x, in_first_y, in_first_z, in_second_x, in_second_y, in_second_z;
  logic [14:0] in_radius;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;
  int          fail_count, pending, checked_count, settings_used;
  bit          steady, hold_pop;
  logic [63:0] planes [7];

  frustum_culling_test_core DUT (.*);

  frustum_culling_test_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // result side: random pops, long hold when asked
  initial begin
    out_pop = 0;
    forever begin
      @(posedge clk);
      if (hold_pop) begin
        out_pop <= 0;
        repeat (300) @(posedge clk);
        hold_pop = 0;
      end else begin
        out_pop <= steady || ($urandom_range(99) >= 14);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [63:0] pack(logic [15:0] a, b, c, d);
    return {d, c, b, a};
  endfunction

  function automatic logic [15:0] rand_coord(bit wide);
    if (wide) return 16'($urandom);
    return 16'($urandom_range(4095)) - 16'd2048;
  endfunction

  // one request, then maybe a gap
  task automatic send(logic [1:0] k, logic [15:0] x0, y0, z0, x1, y1, z1,
                      logic [14:0] r);
    in_push <= 1;
    in_kind <= k;
    in_first_x <= x0; in_first_y <= y0; in_first_z <= z0;
    in_second_x <= x1; in_second_y <= y1; in_second_z <= z1;
    in_radius <= r;
    do @(posedge clk); while (in_full);
    if (!steady && $urandom_range(99) < 14) begin
      in_push <= 0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  task automatic send_random();
    bit wide;
    logic [1:0] k;
    wide = ($urandom_range(3) == 0);
    k = ($urandom_range(19) == 0) ? KIND_UNUSED : 2'($urandom_range(2));
    send(k, rand_coord(wide), rand_coord(wide), rand_coord(wide),
         rand_coord(wide), rand_coord(wide), rand_coord(wide),
         wide ? 15'($urandom) : 15'($urandom_range(1023)));
  endtask

  // wait out every result, then the block's own latency
  task automatic drain();
    in_push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // write all planes plus one index past the end, only while idle
  task automatic load_planes();
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1;
      cfg_index <= 3'(i);
      cfg_wdata <= planes[i];
      @(posedge clk);
    end
    cfg_we <= 0;
    settings_used++;
  endtask

  task automatic random_planes(bit wide);
    for (int i = 0; i < 7; i++)
      planes[i] = wide ? {$urandom, $urandom} :
        pack(16'($urandom_range(1023)) - 16'd512, 16'($urandom_range(1023)) - 16'd512,
             16'($urandom_range(1023)) - 16'd512, 16'($urandom_range(4095)) - 16'd2048);
  endtask

  initial begin
    rst_n = 0; in_push = 0; cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
    in_kind = KIND_POINT; in_radius = '0;
    in_first_x = '0; in_first_y = '0; in_first_z = '0;
    in_second_x = '0; in_second_y = '0; in_second_z = '0;
    steady = 0; hold_pop = 0; settings_used = 1;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // all-zero planes straight after reset, including a sphere against the zero-length planes
    send(KIND_POINT, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 15'h0);
    send(KIND_SPHERE, 16'h8000, 16'h7fff, 16'h0, 16'h0, 16'h0, 16'h0, 15'h7fff);
    send(KIND_BOX, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 15'h0);
    drain();

    // cube of half-size 8 around the origin, last entry is the ignored index
    planes[REG_RIGHT]  = pack(16'hff00, 16'h0, 16'h0, 16'h0800);
    planes[REG_LEFT]   = pack(16'h0100, 16'h0, 16'h0, 16'h0800);
    planes[REG_BOTTOM] = pack(16'h0, 16'h0100, 16'h0, 16'h0800);
    planes[REG_TOP]    = pack(16'h0, 16'hff00, 16'h0, 16'h0800);
    planes[REG_BACK]   = pack(16'h0, 16'h0, 16'h0100, 16'h0800);
    planes[REG_FRONT]  = pack(16'h0, 16'h0, 16'hff00, 16'h0800);
    planes[REG_BEYOND] = 64'hffff_ffff_ffff_ffff;
    load_planes();
    send(KIND_POINT, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 15'h0);
    send(KIND_POINT, 16'h0900, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 15'h0);
    send(KIND_POINT, 16'h0800, 16'hf800, 16'h0800, 16'h0, 16'h0, 16'h0, 15'h0);
    send(KIND_SPHERE, 16'h0a00, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 15'h0100);
    send(KIND_SPHERE, 16'h0a00, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 15'h0300);
    send(KIND_SPHERE, 16'h7fff, 16'h8000, 16'h7fff, 16'h0, 16'h0, 16'h0, 15'h7fff);
    send(KIND_BOX, 16'hf000, 16'hf000, 16'hf000, 16'h1000, 16'h1000, 16'h1000, 15'h0);
    send(KIND_BOX, 16'h0900, 16'h0, 16'h0, 16'h0a00, 16'h0100, 16'h0100, 15'h0);
    // inverted box: min above max on every axis
    send(KIND_BOX, 16'h0100, 16'h0100, 16'h0100, 16'hff00, 16'hff00, 16'hff00, 15'h0);
    send(KIND_BOX, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 15'h0);
    send(KIND_UNUSED, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 15'h7fff);
    drain();

    // extreme components, with a zero-length plane that has a negative offset
    planes[REG_RIGHT]  = pack(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    planes[REG_LEFT]   = pack(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    planes[REG_BOTTOM] = pack(16'h8000, 16'h7fff, 16'h0, 16'h0001);
    planes[REG_TOP]    = pack(16'h0001, 16'h0, 16'h0, 16'h0);
    planes[REG_BACK]   = pack(16'h0, 16'h0, 16'h0, 16'hff00);
    planes[REG_FRONT]  = pack(16'h0, 16'h0, 16'hffff, 16'h7fff);
    planes[REG_BEYOND] = 64'h0;
    load_planes();
    send(KIND_SPHERE, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 15'h0);
    send(KIND_SPHERE, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 15'h0200);
    send(KIND_POINT, 16'h8000, 16'h7fff, 16'h8000, 16'h0, 16'h0, 16'h0, 15'h0);
    send(KIND_BOX, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 15'h0);
    drain();

    // random phases, each with its own plane set
    for (int ph = 0; ph < PHASES; ph++) begin
      random_planes(ph % 3 == 2);
      load_planes();
      steady = (ph == 3);
      if (ph == 5) hold_pop = 1;
      for (int n = 0; n < PER_PHASE; n++) send_random();
      drain();
    end
    steady = 0;

    $display("checked %0d culling results across %0d plane settings", checked_count,
             settings_used);
    $display("points, spheres with renormalization, boxes and the unused kind included");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
